FILE: rtl/tgf_pkg.sv
// Package for the triangle tangent frame block.
// Holds the fixed widths, the controller/datapath command and status structs
// and the output saturation function. Depends on nothing.
package tgf_pkg;

    localparam int SLOT_W  = 10;
    localparam int FIELD_W = 32;
    localparam int DELTA_W = 33;
    localparam int PROD_W  = 66;
    localparam int NUM_W   = 68;
    localparam int QUO_W   = 32;
    localparam int NUM_QUOTIENTS = 6;
    localparam int MUL_STEPS     = 7;

    localparam logic [FIELD_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [FIELD_W-1:0] SAT_NEG = 32'h8000_0000;

    localparam logic ACTION_LOAD     = 1'b0;
    localparam logic ACTION_TRIANGLE = 1'b1;

    typedef struct packed {
        logic       in_ready;
        logic       load_wr;
        logic       tri_start;
        logic       rd_issue;
        logic [1:0] rd_idx;
        logic       delta_en;
        logic       mul_en;
        logic [2:0] mul_step;
        logic       div_init;
        logic       div_step;
        logic       out_load;
    } tgf_cmd_t;

    typedef struct packed {
        logic in_valid;
        logic in_action;
        logic out_free;
    } tgf_sts_t;

    function automatic logic [FIELD_W-1:0] sat_quotient(input logic neg, input logic ovf,
                                                        input logic [QUO_W-1:0] q);
        logic [FIELD_W-1:0] r;
        if (ovf)
        begin
            r = neg ? SAT_NEG : SAT_POS;
        end
        else if (neg)
        begin
            r = (q > SAT_NEG) ? SAT_NEG : (~q + 32'd1);
        end
        else
        begin
            r = q[QUO_W-1] ? SAT_POS : q;
        end
        return r;
    endfunction

endpackage

FILE: rtl/tgf_in_if.sv
// Input channel interface: valid/ready handshake with the vertex/triangle payload.
// Depends on nothing.
interface tgf_in_if;
    logic               valid;
    logic               ready;
    logic               action;
    logic [9:0]         load_slot;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [31:0] tex_u;
    logic signed [31:0] tex_v;
    logic [9:0]         first_corner;
    logic [9:0]         second_corner;
    logic [9:0]         third_corner;

    modport source (output valid, action, load_slot, pos_x, pos_y, pos_z, tex_u, tex_v,
                    first_corner, second_corner, third_corner, input ready);
    modport sink (input valid, action, load_slot, pos_x, pos_y, pos_z, tex_u, tex_v,
                  first_corner, second_corner, third_corner, output ready);
endinterface

FILE: rtl/tgf_out_if.sv
// Output channel interface: valid/ready handshake with the tangent frame payload.
// Depends on nothing.
interface tgf_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] tangent_x;
    logic signed [31:0] tangent_y;
    logic signed [31:0] tangent_z;
    logic signed [31:0] bitangent_x;
    logic signed [31:0] bitangent_y;
    logic signed [31:0] bitangent_z;
    logic               degenerate;

    modport source (output valid, tangent_x, tangent_y, tangent_z, bitangent_x,
                    bitangent_y, bitangent_z, degenerate, input ready);
    modport sink (input valid, tangent_x, tangent_y, tangent_z, bitangent_x,
                  bitangent_y, bitangent_z, degenerate, output ready);
endinterface

FILE: rtl/triangle_tangent_frame.sv
// Triangle tangent frame: load transactions are written to vertex memory on acceptance;
// a triangle transaction runs from acceptance to a valid result through three memory
// reads, seven multiplier steps and 32 steps of the bit-serial dividers, one triangle at a
// time: no new transaction is accepted until the result register is loaded and it is idle.
// Reset clears the controller and the result valid flag; vertex memory is not cleared.
module triangle_tangent_frame #(
    parameter int VERTEX_SLOTS = 1024
) (
    input  logic      clk,
    input  logic      rst_n,
    tgf_in_if.sink    item,
    tgf_out_if.source result
);
    import tgf_pkg::*;

    tgf_cmd_t cmd;
    tgf_sts_t sts;

    tgf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .sts   (sts),
        .cmd   (cmd)
    );

    tgf_datapath #(
        .VERTEX_SLOTS (VERTEX_SLOTS)
    ) u_datapath (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (cmd),
        .sts    (sts),
        .item   (item),
        .result (result)
    );

endmodule

FILE: rtl/tgf_ctrl.sv
// Sequencing controller for the triangle tangent frame block.
// Depends on tgf_pkg; drives the datapath through tgf_cmd_t.
module tgf_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  tgf_pkg::tgf_sts_t sts,
    output tgf_pkg::tgf_cmd_t cmd
);
    import tgf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_RD0, S_RD1, S_RD2, S_RWAIT, S_DELTA,
        S_MUL, S_DRAIN, S_DINIT, S_DIV, S_OUT
    } state_t;

    state_t     state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       accept;

    assign accept = sts.in_valid && (state_reg == S_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (accept && sts.in_action == ACTION_TRIANGLE)
                begin
                    state_next = S_RD0;
                end
            end
            S_RD0:   state_next = S_RD1;
            S_RD1:   state_next = S_RD2;
            S_RD2:   state_next = S_RWAIT;
            S_RWAIT: state_next = S_DELTA;
            S_DELTA:
            begin
                state_next = S_MUL;
                cnt_next   = '0;
            end
            S_MUL:
            begin
                if (cnt_reg == 5'(MUL_STEPS - 1))
                begin
                    state_next = S_DRAIN;
                end
                cnt_next = cnt_reg + 5'd1;
            end
            S_DRAIN: state_next = S_DINIT;
            S_DINIT:
            begin
                state_next = S_DIV;
                cnt_next   = '0;
            end
            S_DIV:
            begin
                if (cnt_reg == 5'(QUO_W - 1))
                begin
                    state_next = S_OUT;
                end
                cnt_next = cnt_reg + 5'd1;
            end
            S_OUT:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_comb
    begin
        cmd           = '0;
        cmd.in_ready  = (state_reg == S_IDLE);
        cmd.load_wr   = accept && sts.in_action == ACTION_LOAD;
        cmd.tri_start = accept && sts.in_action == ACTION_TRIANGLE;
        cmd.rd_issue  = (state_reg == S_RD0) || (state_reg == S_RD1) || (state_reg == S_RD2);
        cmd.rd_idx    = (state_reg == S_RD0) ? 2'd0 : ((state_reg == S_RD1) ? 2'd1 : 2'd2);
        cmd.delta_en  = (state_reg == S_DELTA);
        cmd.mul_en    = (state_reg == S_MUL);
        cmd.mul_step  = cnt_reg[2:0];
        cmd.div_init  = (state_reg == S_DINIT);
        cmd.div_step  = (state_reg == S_DIV);
        cmd.out_load  = (state_reg == S_OUT) && sts.out_free;
    end

endmodule

FILE: rtl/tgf_datapath.sv
// Datapath for the triangle tangent frame block: vertex memory, edge and UV deltas,
// a shared pair of multipliers and six bit-serial dividers. Depends on tgf_pkg and
// the channel interfaces.
module tgf_datapath #(
    parameter int VERTEX_SLOTS = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  tgf_pkg::tgf_cmd_t cmd,
    output tgf_pkg::tgf_sts_t sts,
    tgf_in_if.sink            item,
    tgf_out_if.source         result
);
    import tgf_pkg::*;

    localparam int AW = (VERTEX_SLOTS > 1) ? $clog2(VERTEX_SLOTS) : 1;
    localparam int EW = (AW > SLOT_W) ? AW : SLOT_W;
    localparam int VW = 5 * FIELD_W;

    logic [VW-1:0]              mem [VERTEX_SLOTS];
    logic [EW-1:0]              wr_ext;
    logic                       wr_ok;
    logic [SLOT_W-1:0]          corner_reg [3];
    logic [SLOT_W-1:0]          rd_slot;
    logic [EW-1:0]              rd_ext;
    logic [VW-1:0]              rd_data_reg;
    logic                       rd_ok_reg;
    logic                       rd_pend_reg;
    logic [1:0]                 rd_idx_reg;
    logic [VW-1:0]              vtx_reg [3];

    logic signed [DELTA_W-1:0]  e1_reg [3];
    logic signed [DELTA_W-1:0]  e2_reg [3];
    logic signed [DELTA_W-1:0]  du1_reg, dv1_reg, du2_reg, dv2_reg;

    logic signed [DELTA_W-1:0]  op_a, op_b, op_c, op_d;
    logic signed [PROD_W-1:0]   prod0_reg, prod1_reg;
    logic                       sub_pend_reg;
    logic [2:0]                 sub_idx_reg;
    logic signed [NUM_W-1:0]    num_reg [MUL_STEPS];

    logic [NUM_W-1:0]           dmag;
    logic                       det_zero;

    logic [NUM_W-1:0]           rem_reg [NUM_QUOTIENTS];
    logic [QUO_W-1:0]           nlo_reg [NUM_QUOTIENTS];
    logic [QUO_W-1:0]           q_reg [NUM_QUOTIENTS];
    logic                       ovf_reg [NUM_QUOTIENTS];
    logic                       neg_reg [NUM_QUOTIENTS];
    logic [FIELD_W-1:0]         res [NUM_QUOTIENTS];

    logic [FIELD_W-1:0]         out_reg [NUM_QUOTIENTS];
    logic                       deg_reg;
    logic                       out_valid_reg;

    assign item.ready    = cmd.in_ready;
    assign sts.in_valid  = item.valid;
    assign sts.in_action = item.action;
    assign sts.out_free  = !out_valid_reg || result.ready;

    // Vertex memory.
    assign wr_ext = EW'(item.load_slot);
    assign wr_ok  = 32'(item.load_slot) < 32'(VERTEX_SLOTS);
    assign rd_slot = corner_reg[cmd.rd_idx];
    assign rd_ext  = EW'(rd_slot);

    always_ff @(posedge clk)
    begin
        if (cmd.load_wr && wr_ok)
        begin
            mem[wr_ext[AW-1:0]] <= {item.pos_x, item.pos_y, item.pos_z, item.tex_u, item.tex_v};
        end
        if (cmd.rd_issue)
        begin
            rd_data_reg <= mem[rd_ext[AW-1:0]];
            rd_ok_reg   <= 32'(rd_slot) < 32'(VERTEX_SLOTS);
            rd_idx_reg  <= cmd.rd_idx;
        end
        if (rd_pend_reg)
        begin
            vtx_reg[rd_idx_reg] <= rd_ok_reg ? rd_data_reg : '0;
        end
        if (cmd.tri_start)
        begin
            corner_reg[0] <= item.first_corner;
            corner_reg[1] <= item.second_corner;
            corner_reg[2] <= item.third_corner;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_pend_reg  <= 1'b0;
            sub_pend_reg <= 1'b0;
        end
        else
        begin
            rd_pend_reg  <= cmd.rd_issue;
            sub_pend_reg <= cmd.mul_en;
        end
    end

    // Edge and UV deltas; field k of a vertex word sits at bits [VW-1-32k -: 32].
    always_ff @(posedge clk)
    begin
        if (cmd.delta_en)
        begin
            for (int k = 0; k < 3; k++)
            begin
                e1_reg[k] <= DELTA_W'(signed'(vtx_reg[1][VW-1-FIELD_W*k -: FIELD_W]))
                           - DELTA_W'(signed'(vtx_reg[0][VW-1-FIELD_W*k -: FIELD_W]));
                e2_reg[k] <= DELTA_W'(signed'(vtx_reg[2][VW-1-FIELD_W*k -: FIELD_W]))
                           - DELTA_W'(signed'(vtx_reg[0][VW-1-FIELD_W*k -: FIELD_W]));
            end
            du1_reg <= DELTA_W'(signed'(vtx_reg[1][2*FIELD_W-1 -: FIELD_W]))
                     - DELTA_W'(signed'(vtx_reg[0][2*FIELD_W-1 -: FIELD_W]));
            dv1_reg <= DELTA_W'(signed'(vtx_reg[1][FIELD_W-1:0]))
                     - DELTA_W'(signed'(vtx_reg[0][FIELD_W-1:0]));
            du2_reg <= DELTA_W'(signed'(vtx_reg[2][2*FIELD_W-1 -: FIELD_W]))
                     - DELTA_W'(signed'(vtx_reg[0][2*FIELD_W-1 -: FIELD_W]));
            dv2_reg <= DELTA_W'(signed'(vtx_reg[2][FIELD_W-1:0]))
                     - DELTA_W'(signed'(vtx_reg[0][FIELD_W-1:0]));
        end
    end

    // Step 0 forms the determinant, steps 1-3 the tangent and 4-6 the bitangent numerators.
    always_comb
    begin
        op_a = du1_reg;
        op_b = dv2_reg;
        op_c = du2_reg;
        op_d = dv1_reg;
        case (cmd.mul_step)
            3'd1, 3'd2, 3'd3:
            begin
                op_a = dv2_reg;
                op_b = e1_reg[2'(cmd.mul_step - 3'd1)];
                op_c = dv1_reg;
                op_d = e2_reg[2'(cmd.mul_step - 3'd1)];
            end
            3'd4, 3'd5, 3'd6:
            begin
                op_a = du1_reg;
                op_b = e2_reg[2'(cmd.mul_step - 3'd4)];
                op_c = du2_reg;
                op_d = e1_reg[2'(cmd.mul_step - 3'd4)];
            end
            default:
            begin
                op_a = du1_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_en)
        begin
            prod0_reg   <= op_a * op_b;
            prod1_reg   <= op_c * op_d;
            sub_idx_reg <= cmd.mul_step;
        end
        if (sub_pend_reg)
        begin
            num_reg[sub_idx_reg] <= NUM_W'(prod0_reg) - NUM_W'(prod1_reg);
        end
    end

    assign dmag     = num_reg[0][NUM_W-1] ? (~num_reg[0] + NUM_W'(1)) : num_reg[0];
    assign det_zero = (num_reg[0] == '0);

    // Restoring division of |num| * 2^16 by |det|, one quotient bit per cycle.
    for (genvar j = 0; j < NUM_QUOTIENTS; j++)
    begin : g_div
        logic [NUM_W-1:0] nmag;
        logic [NUM_W-1:0] rem_init;
        logic [NUM_W:0]   r2;
        logic             take;

        assign nmag     = num_reg[j+1][NUM_W-1] ? (~num_reg[j+1] + NUM_W'(1)) : num_reg[j+1];
        assign rem_init = NUM_W'(nmag[NUM_W-1:16]);
        assign r2       = {rem_reg[j], nlo_reg[j][QUO_W-1]};
        assign take     = r2 >= {1'b0, dmag};
        assign res[j]   = sat_quotient(neg_reg[j], ovf_reg[j], q_reg[j]);

        always_ff @(posedge clk)
        begin
            if (cmd.div_init)
            begin
                rem_reg[j] <= rem_init;
                nlo_reg[j] <= {nmag[15:0], 16'd0};
                q_reg[j]   <= '0;
                ovf_reg[j] <= rem_init >= dmag;
                neg_reg[j] <= num_reg[j+1][NUM_W-1] ^ num_reg[0][NUM_W-1];
            end
            else if (cmd.div_step)
            begin
                rem_reg[j] <= take ? NUM_W'(r2 - {1'b0, dmag}) : r2[NUM_W-1:0];
                nlo_reg[j] <= {nlo_reg[j][QUO_W-2:0], 1'b0};
                q_reg[j]   <= {q_reg[j][QUO_W-2:0], take};
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            for (int k = 0; k < NUM_QUOTIENTS; k++)
            begin
                out_reg[k] <= det_zero ? '0 : res[k];
            end
            deg_reg <= det_zero;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.tangent_x   = out_reg[0];
    assign result.tangent_y   = out_reg[1];
    assign result.tangent_z   = out_reg[2];
    assign result.bitangent_x = out_reg[3];
    assign result.bitangent_y = out_reg[4];
    assign result.bitangent_z = out_reg[5];
    assign result.degenerate  = deg_reg;

    a_out_load_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || result.ready))
        else $error("result register loaded while still holding an untaken transaction");

    a_load_wr_accept: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_wr |-> (item.valid && item.ready && item.action == ACTION_LOAD))
        else $error("vertex write without an accepted load transaction");

    a_rd_capture: assert property (@(posedge clk) disable iff (!rst_n)
        rd_pend_reg |-> $past(cmd.rd_issue))
        else $error("vertex capture without a preceding memory read");

    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.mul_en || cmd.div_step || cmd.rd_issue) |-> !item.ready)
        else $error("input ready while a triangle is in progress");

endmodule

FILE: sim/triangle_tangent_frame_tb.sv
// Testbench for triangle_tangent_frame: drives vertex loads and triangle transactions,
// predicts untyped frames in exact wide arithmetic and checks every result field.
// Depends on tgf_pkg, tgf_in_if, tgf_out_if and the triangle_tangent_frame RTL.
`timescale 1ns / 1ps

module triangle_tangent_frame_tb;
    import tgf_pkg::*;

    typedef struct {
        logic signed [31:0] tan_x, tan_y, tan_z;
        logic signed [31:0] bit_x, bit_y, bit_z;
        logic               degen;
    } frame_t;

    typedef struct {
        logic               action;
        logic [9:0]         slot;
        logic signed [31:0] px, py, pz, tu, tv;
        logic [9:0]         ca, cb, cc;
        bit                 typed;
        frame_t             want;
    } row_t;

    localparam logic signed [31:0] ONE = 32'h0001_0000;
    localparam int RANDOM_ITEMS = 1600;
    localparam int LONG_HOLD = 500;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    tgf_in_if  item_ch();
    tgf_out_if result_ch();

    triangle_tangent_frame dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item_ch),
        .result (result_ch)
    );

    logic signed [31:0] pos_x_mem [1024];
    logic signed [31:0] pos_y_mem [1024];
    logic signed [31:0] pos_z_mem [1024];
    logic signed [31:0] tex_u_mem [1024];
    logic signed [31:0] tex_v_mem [1024];
    bit                 loaded [1024];
    int                 loaded_slots[$];

    frame_t expected_frames[$];
    row_t   stimulus_table[$];
    int     error_count = 0;
    bit     hold_request = 1'b0;
    bit     calm = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch %s: got %h, expected %h at %0t", what, got, want, $realtime);
        error_count++;
    endtask

    function automatic logic signed [31:0] q16_quotient(input logic signed [127:0] num,
                                                        input logic signed [127:0] den);
        logic [127:0] n;
        logic [127:0] d;
        logic [127:0] q;
        logic         neg;
        neg = num[127] ^ den[127];
        n = num[127] ? -num : num;
        d = den[127] ? -den : den;
        q = (n << 16) / d;
        if (neg)
        begin
            if (q > 128'h8000_0000)
            begin
                return SAT_NEG;
            end
            return -q[31:0];
        end
        if (q > 128'h7FFF_FFFF)
        begin
            return SAT_POS;
        end
        return q[31:0];
    endfunction

    function automatic frame_t tangent_frame(input int a, input int b, input int c);
        logic signed [63:0]  du1, dv1, du2, dv2;
        logic signed [63:0]  e1 [3];
        logic signed [63:0]  e2 [3];
        logic signed [127:0] det, tn, bn;
        logic signed [31:0]  tq [3];
        logic signed [31:0]  bq [3];
        frame_t              f;
        du1 = 64'(tex_u_mem[b]) - 64'(tex_u_mem[a]);
        dv1 = 64'(tex_v_mem[b]) - 64'(tex_v_mem[a]);
        du2 = 64'(tex_u_mem[c]) - 64'(tex_u_mem[a]);
        dv2 = 64'(tex_v_mem[c]) - 64'(tex_v_mem[a]);
        e1[0] = 64'(pos_x_mem[b]) - 64'(pos_x_mem[a]);
        e1[1] = 64'(pos_y_mem[b]) - 64'(pos_y_mem[a]);
        e1[2] = 64'(pos_z_mem[b]) - 64'(pos_z_mem[a]);
        e2[0] = 64'(pos_x_mem[c]) - 64'(pos_x_mem[a]);
        e2[1] = 64'(pos_y_mem[c]) - 64'(pos_y_mem[a]);
        e2[2] = 64'(pos_z_mem[c]) - 64'(pos_z_mem[a]);
        det = 128'(du1) * 128'(dv2) - 128'(du2) * 128'(dv1);
        f.degen = (det == 0);
        for (int k = 0; k < 3; k++)
        begin
            tn = 128'(dv2) * 128'(e1[k]) - 128'(dv1) * 128'(e2[k]);
            bn = 128'(du1) * 128'(e2[k]) - 128'(du2) * 128'(e1[k]);
            tq[k] = f.degen ? 32'sd0 : q16_quotient(tn, det);
            bq[k] = f.degen ? 32'sd0 : q16_quotient(bn, det);
        end
        f.tan_x = tq[0];
        f.tan_y = tq[1];
        f.tan_z = tq[2];
        f.bit_x = bq[0];
        f.bit_y = bq[1];
        f.bit_z = bq[2];
        return f;
    endfunction

    function automatic frame_t mk_frame(input logic signed [31:0] tx, ty, tz, bx, by, bz,
                                        input logic dg);
        frame_t f;
        f.tan_x = tx;
        f.tan_y = ty;
        f.tan_z = tz;
        f.bit_x = bx;
        f.bit_y = by;
        f.bit_z = bz;
        f.degen = dg;
        return f;
    endfunction

    function automatic row_t mk_load(input int s, input logic signed [31:0] px, py, pz,
                                     tu, tv);
        row_t r;
        r = '{default: '0};
        r.action = ACTION_LOAD;
        r.slot = 10'(s);
        r.px = px;
        r.py = py;
        r.pz = pz;
        r.tu = tu;
        r.tv = tv;
        return r;
    endfunction

    function automatic row_t mk_tri(input int a, b, c, input bit typed, input frame_t want);
        row_t r;
        r = '{default: '0};
        r.action = ACTION_TRIANGLE;
        r.ca = 10'(a);
        r.cb = 10'(b);
        r.cc = 10'(c);
        r.typed = typed;
        r.want = want;
        return r;
    endfunction

    function automatic logic signed [31:0] random_q16();
        case ($urandom_range(0, 5))
            0: return $urandom();
            1: return $urandom_range(0, 3) == 0 ? SAT_POS : ($urandom_range(0, 1) ? SAT_NEG : 0);
            2: return $signed($urandom_range(0, 32'h000F_FFFF)) - 32'sh0008_0000;
            3: return $signed($urandom_range(0, 32'h0000_00FF)) - 32'sh0000_0080;
            default: return $signed($urandom_range(0, 32'h03FF_FFFF)) - 32'sh0200_0000;
        endcase
    endfunction

    task automatic send_item(input row_t r);
        frame_t f;
        @(negedge clk);
        item_ch.valid         <= 1'b1;
        item_ch.action        <= r.action;
        item_ch.load_slot     <= r.slot;
        item_ch.pos_x         <= r.px;
        item_ch.pos_y         <= r.py;
        item_ch.pos_z         <= r.pz;
        item_ch.tex_u         <= r.tu;
        item_ch.tex_v         <= r.tv;
        item_ch.first_corner  <= r.ca;
        item_ch.second_corner <= r.cb;
        item_ch.third_corner  <= r.cc;
        do
        begin
            @(posedge clk);
        end
        while (!item_ch.ready);
        if (r.action == ACTION_LOAD)
        begin
            pos_x_mem[r.slot] = r.px;
            pos_y_mem[r.slot] = r.py;
            pos_z_mem[r.slot] = r.pz;
            tex_u_mem[r.slot] = r.tu;
            tex_v_mem[r.slot] = r.tv;
            if (!loaded[r.slot])
            begin
                loaded[r.slot] = 1'b1;
                loaded_slots.insert(loaded_slots.size(), int'(r.slot));
            end
        end
        else
        begin
            f = r.typed ? r.want : tangent_frame(r.ca, r.cb, r.cc);
            expected_frames.insert(expected_frames.size(), f);
        end
        if (!calm && $urandom_range(0, 2) == 0)
        begin
            @(negedge clk);
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(0, 9) == 0 ? $urandom_range(10, 60) : $urandom_range(0, 3))
            begin
                @(negedge clk);
            end
        end
    endtask

    initial
    begin
        item_ch.valid         = 1'b0;
        item_ch.action        = ACTION_LOAD;
        item_ch.load_slot     = '0;
        item_ch.pos_x         = '0;
        item_ch.pos_y         = '0;
        item_ch.pos_z         = '0;
        item_ch.tex_u         = '0;
        item_ch.tex_v         = '0;
        item_ch.first_corner  = '0;
        item_ch.second_corner = '0;
        item_ch.third_corner  = '0;
        result_ch.ready       = 1'b0;
    end

    always @(posedge clk)
    begin
        frame_t w;
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            if (expected_frames.size() == 0)
            begin
                report_mismatch("unexpected result", result_ch.tangent_x, 32'h0);
            end
            else
            begin
                w = expected_frames.pop_front();
                if (result_ch.tangent_x !== w.tan_x)
                    report_mismatch("tangent_x", result_ch.tangent_x, w.tan_x);
                if (result_ch.tangent_y !== w.tan_y)
                    report_mismatch("tangent_y", result_ch.tangent_y, w.tan_y);
                if (result_ch.tangent_z !== w.tan_z)
                    report_mismatch("tangent_z", result_ch.tangent_z, w.tan_z);
                if (result_ch.bitangent_x !== w.bit_x)
                    report_mismatch("bitangent_x", result_ch.bitangent_x, w.bit_x);
                if (result_ch.bitangent_y !== w.bit_y)
                    report_mismatch("bitangent_y", result_ch.bitangent_y, w.bit_y);
                if (result_ch.bitangent_z !== w.bit_z)
                    report_mismatch("bitangent_z", result_ch.bitangent_z, w.bit_z);
                if (result_ch.degenerate !== w.degen)
                    report_mismatch("degenerate", 32'(result_ch.degenerate), 32'(w.degen));
            end
        end
    end

    initial
    begin
        int gap;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_request)
            begin
                result_ch.ready <= 1'b0;
                repeat (LONG_HOLD)
                begin
                    @(negedge clk);
                end
                hold_request = 1'b0;
            end
            gap = calm ? 0 : ($urandom_range(0, 19) == 0 ? $urandom_range(10, 80)
                                                       : ($urandom_range(0, 1) ? 0
                                                       : $urandom_range(1, 3)));
            if (gap > 0)
            begin
                result_ch.ready <= 1'b0;
                repeat (gap - 1)
                begin
                    @(negedge clk);
                end
                @(negedge clk);
            end
            result_ch.ready <= 1'b1;
        end
    end

    initial
    begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        row_t r;
        int   s;
        stimulus_table.insert(stimulus_table.size(), mk_load(0, 0, 0, 0, 0, 0));
        stimulus_table.insert(stimulus_table.size(), mk_load(1, ONE, 0, 0, ONE, 0));
        stimulus_table.insert(stimulus_table.size(), mk_load(2, 0, ONE, 0, 0, ONE));
        stimulus_table.insert(stimulus_table.size(),
                              mk_tri(0, 1, 2, 1'b1, mk_frame(ONE, 0, 0, 0, ONE, 0, 1'b0)));
        stimulus_table.insert(stimulus_table.size(),
                              mk_load(3, SAT_POS, SAT_POS, SAT_POS, 32'sd1, 0));
        stimulus_table.insert(stimulus_table.size(),
                              mk_load(4, SAT_NEG, SAT_NEG, SAT_NEG, 0, 32'sd1));
        stimulus_table.insert(stimulus_table.size(),
                              mk_tri(0, 3, 4, 1'b1, mk_frame(SAT_POS, SAT_POS, SAT_POS,
                                                             SAT_NEG, SAT_NEG, SAT_NEG, 1'b0)));
        stimulus_table.insert(stimulus_table.size(),
                              mk_tri(1, 1, 1, 1'b1, mk_frame(0, 0, 0, 0, 0, 0, 1'b1)));
        stimulus_table.insert(stimulus_table.size(),
                              mk_load(6, 0, 0, ONE, 32'sh0002_0000, 0));
        stimulus_table.insert(stimulus_table.size(),
                              mk_tri(0, 1, 6, 1'b1, mk_frame(0, 0, 0, 0, 0, 0, 1'b1)));
        stimulus_table.insert(stimulus_table.size(),
                              mk_load(1023, SAT_NEG, SAT_POS, -32'sd1, SAT_POS, SAT_NEG));
        stimulus_table.insert(stimulus_table.size(),
                              mk_load(5, 32'sh0003_8000, -32'sh0001_2000, 32'sh0000_4000,
                                      32'sh0001_2345, -32'sh0000_8765));
        stimulus_table.insert(stimulus_table.size(),
                              mk_tri(1023, 5, 2, 1'b0, mk_frame(0, 0, 0, 0, 0, 0, 1'b0)));
        stimulus_table.insert(stimulus_table.size(),
                              mk_tri(5, 1023, 0, 1'b0, mk_frame(0, 0, 0, 0, 0, 0, 1'b0)));
        stimulus_table.insert(stimulus_table.size(),
                              mk_tri(3, 4, 1023, 1'b0, mk_frame(0, 0, 0, 0, 0, 0, 1'b0)));
        stimulus_table.insert(stimulus_table.size(),
                              mk_tri(2, 5, 1, 1'b0, mk_frame(0, 0, 0, 0, 0, 0, 1'b0)));
        stimulus_table.insert(stimulus_table.size(),
                              mk_load(1023, SAT_POS, SAT_NEG, 0, SAT_NEG, SAT_POS));
        stimulus_table.insert(stimulus_table.size(),
                              mk_tri(1023, 3, 4, 1'b0, mk_frame(0, 0, 0, 0, 0, 0, 1'b0)));

        repeat (9)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        rst_n = 1'b1;

        foreach (stimulus_table[i])
        begin
            send_item(stimulus_table[i]);
        end

        for (int i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i == 300)
            begin
                hold_request = 1'b1;
            end
            calm = (i >= 600 && i < 750);
            if (i == 1000)
            begin
                @(negedge clk);
                item_ch.valid <= 1'b0;
                while (expected_frames.size() != 0)
                begin
                    @(posedge clk);
                end
            end
            r = '{default: '0};
            r.action = ($urandom_range(0, 99) < 35) ? ACTION_LOAD : ACTION_TRIANGLE;
            r.slot = 10'($urandom());
            r.px = $urandom();
            r.py = $urandom();
            r.pz = $urandom();
            r.tu = $urandom();
            r.tv = $urandom();
            r.ca = 10'($urandom());
            r.cb = 10'($urandom());
            r.cc = 10'($urandom());
            if (r.action == ACTION_LOAD)
            begin
                if ($urandom_range(0, 9) < 7)
                begin
                    r.slot = 10'($urandom_range(0, 31));
                end
                r.px = random_q16();
                r.py = random_q16();
                r.pz = random_q16();
                r.tu = random_q16();
                r.tv = random_q16();
            end
            else
            begin
                s = loaded_slots.size();
                r.ca = 10'(loaded_slots[$urandom_range(0, s - 1)]);
                r.cb = 10'(loaded_slots[$urandom_range(0, s - 1)]);
                r.cc = ($urandom_range(0, 15) == 0) ? r.cb
                                                    : 10'(loaded_slots[$urandom_range(0, s - 1)]);
            end
            send_item(r);
        end

        @(negedge clk);
        item_ch.valid <= 1'b0;
        while (expected_frames.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (100)
        begin
            @(posedge clk);
        end
        if (error_count == 0)
        begin
            $display("TB_OK");
        end
        else
        begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

FILE: triangle_tangent_frame.f
rtl/tgf_pkg.sv
rtl/tgf_in_if.sv
rtl/tgf_out_if.sv
rtl/tgf_ctrl.sv
rtl/tgf_datapath.sv
rtl/triangle_tangent_frame.sv
sim/triangle_tangent_frame_tb.sv
